// ----- design/mhpq_pkg.sv -----
// shared constants, codes and types of the max-heap priority queue
`timescale 1ns / 1ps

package mhpq_pkg;

  // sizing
  localparam int CAPACITY     = 256;
  localparam int HANDLE_COUNT = 256;
  localparam int KEY_BITS     = 32;

  // derived widths
  localparam int SLOT_W   = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int HIDX_W   = $clog2(HANDLE_COUNT);
  localparam int HANDLE_W = 8;
  localparam int CHILD_W  = SLOT_W + 1;

  // request codes
  typedef enum logic [1:0] {
    REQ_INSERT  = 2'd0,
    REQ_EXTRACT = 2'd1,
    REQ_REMOVE  = 2'd2,
    REQ_NOP     = 2'd3
  } req_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_PRESENT = 3'd4
  } status_e;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_FETCH,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_SEL,
    S_DN_CMP,
    S_PLACE,
    S_DONE
  } state_e;

  // one heap slot
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [KEY_BITS-1:0] key;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- design/max_heap_priority_queue.sv -----
// max-heap priority queue: slot ram, position ram and the sift sequencer
// a request is registered and checked against its lookups, then sifts up one parent at a time on
//   insert or down one child level at a time on extract; remove fetches the hole key before it sifts
// throughput: one request at a time, the next one taken only after the result loads;
//   one shared key comparator sets the pace
// reset: queue empty, all handles absent through per-handle valid flops; rams not reset
`timescale 1ns / 1ps

module max_heap_priority_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   req_type_i,
  input  logic [31:0]                  block_key_i,
  input  logic [mhpq_pkg::HANDLE_W-1:0] block_handle_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2:0]                   status_o,
  output logic [7:0]                   out_handle_o,
  output logic [31:0]                  out_key_o,
  output logic [8:0]                   entry_count_o
);

  import mhpq_pkg::*;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] t;
    t = s - SLOT_W'(1);
    return t[ADDR_W-1:0];
  endfunction

  state_e               state_q, state_d;
  logic [SLOT_W-1:0]    fill_q, fill_d;
  logic [SLOT_W-1:0]    hole_q, hole_d;
  logic [SLOT_W-1:0]    cidx_q, cidx_d;
  entry_t               mov_q, mov_d;
  entry_t               child_q, child_d;
  logic                 first_q, first_d;
  req_e                 req_q;
  logic [KEY_BITS-1:0]  key_q;
  logic [HANDLE_W-1:0]  hdl_q;
  logic                 pos_hit_q;
  logic [HANDLE_COUNT-1:0] pos_vld_q;
  status_e              res_status_q, res_status_d;
  logic [HANDLE_W-1:0]  res_handle_q, res_handle_d;
  logic [KEY_BITS-1:0]  res_key_q, res_key_d;
  logic                 out_valid_q, out_valid_d;
  status_e              out_status_q;
  logic [HANDLE_W-1:0]  out_handle_q;
  logic [KEY_BITS-1:0]  out_key_q;
  logic [SLOT_W-1:0]    out_count_q;

  // ram ports
  logic                 slot_we;
  logic [ADDR_W-1:0]    slot_waddr, slot_raddr_a, slot_raddr_b;
  entry_t               slot_wdata, slot_rd_a, slot_rd_b;
  logic                 pos_we;
  logic [HIDX_W-1:0]    pos_waddr, pos_raddr;
  logic [SLOT_W-1:0]    pos_wdata, pos_rd;

  // entry write request and valid flag updates
  logic                 wr_en;
  logic [SLOT_W-1:0]    wr_slot;
  entry_t               wr_ent;
  logic                 vld_clr;
  logic [HIDX_W-1:0]    vld_clr_idx;

  // shared comparator
  logic [KEY_BITS-1:0]  cmp_a, cmp_b;
  logic                 cmp_gt;

  // decision terms
  logic                 in_fire, load_out;
  logic                 hvalid, ins_ok, ext_ok, rem_ok;
  status_e              chk_status;
  logic [CHILD_W-1:0]   lidx;
  logic                 no_child, has_r, fetch_last;
  logic [SLOT_W-1:0]    par_idx;

  assign in_fire  = in_valid_i && (state_q == S_IDLE);
  assign load_out = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  assign hvalid = 32'(hdl_q) < HANDLE_COUNT;
  assign ins_ok = hvalid && !pos_hit_q && (32'(fill_q) < CAPACITY);
  assign ext_ok = fill_q != '0;
  assign rem_ok = (fill_q != '0) && hvalid && pos_hit_q && (pos_rd <= fill_q);

  assign lidx       = {hole_q, 1'b0};
  assign no_child   = lidx > CHILD_W'(fill_q);
  assign has_r      = (lidx + CHILD_W'(1)) <= CHILD_W'(fill_q);
  assign fetch_last = CHILD_W'(hole_q) == (CHILD_W'(fill_q) + CHILD_W'(1));
  assign par_idx    = hole_q >> 1;

  // status of the request once the lookups are in
  always_comb begin
    chk_status = ST_OK;
    case (req_q)
      REQ_INSERT: begin
        if (!hvalid) chk_status = ST_ABSENT;
        else if (pos_hit_q) chk_status = ST_PRESENT;
        else if (!ins_ok) chk_status = ST_FULL;
      end
      REQ_EXTRACT: begin
        if (!ext_ok) chk_status = ST_EMPTY;
      end
      REQ_REMOVE: begin
        if (fill_q == '0) chk_status = ST_EMPTY;
        else if (!rem_ok) chk_status = ST_ABSENT;
      end
      default: chk_status = ST_OK;
    endcase
  end

  // comparator operand select
  always_comb begin
    case (state_q)
      S_UP_CMP: begin
        cmp_a = mov_q.key;
        cmp_b = slot_rd_a.key;
      end
      S_DN_SEL: begin
        cmp_a = slot_rd_a.key;
        cmp_b = slot_rd_b.key;
      end
      default: begin
        cmp_a = child_q.key;
        cmp_b = mov_q.key;
      end
    endcase
  end

  assign cmp_gt = cmp_a > cmp_b;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = S_CHECK;
      end
      S_CHECK: begin
        state_d = S_DONE;
        case (req_q)
          REQ_INSERT:  if (ins_ok && fill_q != '0) state_d = S_UP_RD;
          REQ_EXTRACT: if (ext_ok && fill_q != SLOT_W'(1)) state_d = S_DN_RD;
          REQ_REMOVE:  if (rem_ok) state_d = S_FETCH;
          default:     state_d = S_DONE;
        endcase
      end
      S_FETCH: begin
        if (fetch_last) state_d = S_DONE;
        else if (hole_q != SLOT_W'(1)) state_d = S_UP_RD;
        else state_d = S_DN_RD;
      end
      S_UP_RD: state_d = S_UP_CMP;
      S_UP_CMP: begin
        if (cmp_gt) state_d = (par_idx == SLOT_W'(1)) ? S_PLACE : S_UP_RD;
        else if (first_q) state_d = S_DN_RD;
        else state_d = S_DONE;
      end
      S_DN_RD: state_d = no_child ? S_DONE : S_DN_SEL;
      S_DN_SEL: state_d = S_DN_CMP;
      S_DN_CMP: state_d = cmp_gt ? S_DN_RD : S_DONE;
      S_PLACE: state_d = S_DONE;
      S_DONE: begin
        if (load_out) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    fill_d       = fill_q;
    hole_d       = hole_q;
    cidx_d       = cidx_q;
    mov_d        = mov_q;
    child_d      = child_q;
    first_d      = first_q;
    res_status_d = res_status_q;
    res_handle_d = res_handle_q;
    res_key_d    = res_key_q;
    wr_en        = 1'b0;
    wr_slot      = hole_q;
    wr_ent       = mov_q;
    vld_clr      = 1'b0;
    vld_clr_idx  = hdl_q[HIDX_W-1:0];
    slot_raddr_a = slot_addr(par_idx);
    slot_raddr_b = slot_addr(fill_q);

    unique case (state_q)
      S_IDLE: begin
        // root and last slot are read for every request
        slot_raddr_a = '0;
        res_status_d = ST_OK;
        res_handle_d = '0;
        res_key_d    = '0;
        first_d      = 1'b0;
      end
      S_CHECK: begin
        res_status_d = chk_status;
        slot_raddr_a = slot_addr(pos_rd);
        case (req_q)
          REQ_INSERT: begin
            if (ins_ok) begin
              fill_d = fill_q + SLOT_W'(1);
              hole_d = fill_q + SLOT_W'(1);
              mov_d  = '{handle: hdl_q, key: key_q};
              // first entry lands on the root right away
              if (fill_q == '0) begin
                wr_en   = 1'b1;
                wr_slot = SLOT_W'(1);
                wr_ent  = '{handle: hdl_q, key: key_q};
              end
            end
          end
          REQ_EXTRACT: begin
            if (ext_ok) begin
              res_handle_d = slot_rd_a.handle;
              res_key_d    = slot_rd_a.key;
              vld_clr      = 1'b1;
              vld_clr_idx  = slot_rd_a.handle[HIDX_W-1:0];
              fill_d       = fill_q - SLOT_W'(1);
              hole_d       = SLOT_W'(1);
              mov_d        = slot_rd_b;
            end
          end
          REQ_REMOVE: begin
            if (rem_ok) begin
              res_handle_d = hdl_q;
              vld_clr      = 1'b1;
              fill_d       = fill_q - SLOT_W'(1);
              hole_d       = pos_rd;
              mov_d        = slot_rd_b;
              first_d      = 1'b1;
            end
          end
          default: res_status_d = ST_OK;
        endcase
      end
      S_FETCH: begin
        res_key_d = slot_rd_a.key;
      end
      S_UP_RD: begin
        slot_raddr_a = slot_addr(par_idx);
      end
      S_UP_CMP: begin
        first_d = 1'b0;
        if (cmp_gt) begin
          // parent moves down into the hole
          wr_en   = 1'b1;
          wr_ent  = slot_rd_a;
          hole_d  = par_idx;
        end else if (!first_q) begin
          wr_en = 1'b1;
        end
      end
      S_DN_RD: begin
        slot_raddr_a = slot_addr(lidx[SLOT_W-1:0]);
        slot_raddr_b = lidx[ADDR_W-1:0];
        if (no_child) begin
          wr_en = 1'b1;
        end
      end
      S_DN_SEL: begin
        // left wins when strictly greater or when there is no right child
        if (!has_r || cmp_gt) begin
          child_d = slot_rd_a;
          cidx_d  = lidx[SLOT_W-1:0];
        end else begin
          child_d = slot_rd_b;
          cidx_d  = lidx[SLOT_W-1:0] + SLOT_W'(1);
        end
      end
      S_DN_CMP: begin
        wr_en = 1'b1;
        if (cmp_gt) begin
          wr_ent = child_q;
          hole_d = cidx_q;
        end
      end
      S_PLACE: begin
        wr_en = 1'b1;
      end
      S_DONE: begin
        wr_en = 1'b0;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // ram write side follows the entry write request
  assign slot_we    = wr_en;
  assign slot_waddr = slot_addr(wr_slot);
  assign slot_wdata = wr_ent;
  assign pos_we     = wr_en;
  assign pos_waddr  = wr_ent.handle[HIDX_W-1:0];
  assign pos_wdata  = wr_slot;
  assign pos_raddr  = block_handle_i[HIDX_W-1:0];

  // output register
  assign out_valid_d = load_out ? 1'b1 : (out_valid_q && out_stall_i);

  mhpq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_slot_ram (
    .clk_i    (clk_i),
    .we_i     (slot_we),
    .waddr_i  (slot_waddr),
    .wdata_i  (slot_wdata),
    .raddr_a_i(slot_raddr_a),
    .rdata_a_o(slot_rd_a),
    .raddr_b_i(slot_raddr_b),
    .rdata_b_o(slot_rd_b)
  );

  mhpq_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(HANDLE_COUNT)
  ) u_pos_ram (
    .clk_i    (clk_i),
    .we_i     (pos_we),
    .waddr_i  (pos_waddr),
    .wdata_i  (pos_wdata),
    .raddr_a_i(pos_raddr),
    .rdata_a_o(pos_rd),
    .raddr_b_i(pos_raddr),
    .rdata_b_o()
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      pos_vld_q   <= '0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      if (vld_clr) pos_vld_q[vld_clr_idx] <= 1'b0;
      if (wr_en) pos_vld_q[wr_ent.handle[HIDX_W-1:0]] <= 1'b1;
    end
  end

  // working and result registers
  always_ff @(posedge clk_i) begin
    hole_q       <= hole_d;
    cidx_q       <= cidx_d;
    mov_q        <= mov_d;
    child_q      <= child_d;
    first_q      <= first_d;
    res_status_q <= res_status_d;
    res_handle_q <= res_handle_d;
    res_key_q    <= res_key_d;
    if (in_fire) begin
      req_q     <= req_e'(req_type_i);
      key_q     <= block_key_i[KEY_BITS-1:0];
      hdl_q     <= block_handle_i;
      pos_hit_q <= pos_vld_q[block_handle_i[HIDX_W-1:0]];
    end
    if (load_out) begin
      out_status_q <= res_status_q;
      out_handle_q <= res_handle_q;
      out_key_q    <= res_key_q;
      out_count_q  <= fill_q;
    end
  end

  assign in_stall_o    = state_q != S_IDLE;
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign out_handle_o  = out_handle_q;
  assign out_key_o     = 32'(out_key_q);
  assign entry_count_o = 9'(out_count_q);

endmodule

// ----- design/mhpq_ram.sv -----
// generic ram: one write port, two registered read ports
`timescale 1ns / 1ps

module mhpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered reads
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ----- design/mhpq_checker.sv -----
// port-level checker for the max-heap priority queue and its bind
`timescale 1ns / 1ps

module mhpq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic [7:0]  out_handle_o,
  input logic [31:0] out_key_o,
  input logic [8:0]  entry_count_o
);

  import mhpq_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(out_key_o) && $stable(out_handle_o) && $stable(entry_count_o))
    else $error("result beat changed while stalled");

  // one request in flight: accepting a beat closes the input
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a request is in flight");

  // empty answers only with no entries left
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY) |-> entry_count_o == '0)
    else $error("empty status with entries present");

  // full answers only at capacity
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> entry_count_o == 9'(CAPACITY))
    else $error("full status below capacity");

  // refused requests return no entry
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (out_handle_o == '0) && (out_key_o == '0))
    else $error("refused request returned an entry");

endmodule

bind max_heap_priority_queue mhpq_checker u_mhpq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .out_handle_o (out_handle_o),
  .out_key_o    (out_key_o),
  .entry_count_o(entry_count_o)
);
